[rtl/core/assert_macros.svh]
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

[rtl/core/pbsd_pkg.sv]
`timescale 1ns / 1ps
package pbsd_pkg;
   localparam int COORD_WIDTH = 20;
   localparam int HALF_Q14 = 8192;
   localparam int NSTAGE = 41;
   localparam logic [2:0] CSR_ROW0 = 3'd0;
   localparam logic [2:0] CSR_ROW1 = 3'd1;
   localparam logic [2:0] CSR_ROW2 = 3'd2;
   localparam logic [2:0] CSR_TRANS = 3'd3;
   localparam logic [2:0] CSR_SCALE = 3'd4;
   localparam logic [2:0] CSR_ISCALE = 3'd5;

   typedef struct packed {
      logic        is_inside;
      logic [23:0] signed_distance;
      logic [22:0] unsigned_distance;
      logic [2:0]  face_index;
      logic [23:0] closest_x;
      logic [23:0] closest_y;
      logic [23:0] closest_z;
   } result_type;
endpackage

[rtl/core/pbsd_local.sv]
`timescale 1ns / 1ps
// Point to local frame: subtract, rotate, saturate, scale, round. 4 stages.
module pbsd_local (
   input  logic clock,
   input  logic en,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] px, py, pz,
   input  logic [47:0] row0, row1, row2,
   input  logic [59:0] trans,
   input  logic [19:0] iscale,
   output logic signed [31:0] loc_out [3]
);
   localparam int W = pbsd_pkg::COORD_WIDTH;
   logic signed [W:0] d_ff [3], d_in [3];
   logic signed [W+17:0] p_ff [3][3];
   logic signed [W+19:0] s_ff [3];
   logic signed [43:0] v_in [3];
   logic signed [64:0] m_ff [3];
   logic signed [64:0] r_in [3];

   function automatic logic signed [W-1:0] tcoord(input logic [59:0] t, input int k);
      logic [63:0] tt;
      tt = {4'b0, t};
      if (k * W >= 64) return '0;
      return W'(tt >> (k * W));
   endfunction

   function automatic logic signed [15:0] rent(input logic [47:0] r, input int c);
      return r[16*c +: 16];
   endfunction

   always_comb begin
      d_in[0] = (W+1)'(px) - (W+1)'(tcoord(trans, 0));
      d_in[1] = (W+1)'(py) - (W+1)'(tcoord(trans, 1));
      d_in[2] = (W+1)'(pz) - (W+1)'(tcoord(trans, 2));
      for (int i = 0; i < 3; i++) begin
         if (s_ff[i] > 44'sd4398046511104) v_in[i] = 44'sd4398046511104;
         else if (s_ff[i] < -44'sd4398046511104) v_in[i] = -44'sd4398046511104;
         else v_in[i] = 44'(s_ff[i]);
         r_in[i] = (m_ff[i] + 65'sd8388608) >>> 24;
         if (r_in[i] > 65'sd2147483647) loc_out[i] = 32'h7fffffff;
         else if (r_in[i] < -65'sd2147483648) loc_out[i] = 32'h80000000;
         else loc_out[i] = 32'(r_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= d_in[i];
            p_ff[i][0] <= (W+18)'(rent(row0, i) * d_ff[0]);
            p_ff[i][1] <= (W+18)'(rent(row1, i) * d_ff[1]);
            p_ff[i][2] <= (W+18)'(rent(row2, i) * d_ff[2]);
            s_ff[i] <= (W+20)'(p_ff[i][0]) + (W+20)'(p_ff[i][1]) + (W+20)'(p_ff[i][2]);
            m_ff[i] <= 65'(v_in[i]) * $signed({45'b0, iscale});
         end
      end
   end
endmodule

[rtl/core/pbsd_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined restoring square root: input register plus 32 stages, one result bit each.
module pbsd_sqrt (
   input  logic clock,
   input  logic en,
   input  logic [63:0] n_in,
   output logic [31:0] root
);
   logic [63:0] rem_ff [33];
   logic [31:0] res_ff [33];
   logic [63:0] rem_in [32];
   logic [31:0] res_in [32];
   logic [65:0] trial;

   always_comb begin
      trial = '0;
      for (int k = 0; k < 32; k++) begin
         trial = {2'b0, rem_ff[k]} - ({34'b0, res_ff[k]} << (32 - k))
                 - (66'd1 << (2 * (31 - k)));
         if (!trial[65]) begin
            rem_in[k] = trial[63:0];
            res_in[k] = res_ff[k] | (32'd1 << (31 - k));
         end else begin
            rem_in[k] = rem_ff[k];
            res_in[k] = res_ff[k];
         end
      end
      root = res_ff[32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n_in;
         res_ff[0] <= '0;
         for (int k = 0; k < 32; k++) begin
            rem_ff[k+1] <= rem_in[k];
            res_ff[k+1] <= res_in[k];
         end
      end
   end
endmodule

[rtl/core/point_box_signed_distance.sv]
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | point_x/y/z
// rsp     | out | rsp_valid/rsp_ready | distances, face, closest point
// csr     | in  | csr_valid/csr_ready | csr_index, csr_data
// One word per cycle while the pipeline advances; stages: 4 mapping, 1 gap/excess,
// 1 sum, 33 square root, 1 scale, 1 result register. The pipeline
// advances whenever the result register is empty or being drained.
// Reset (synchronous) clears valids and loads identity configuration.
`include "assert_macros.svh"
module point_box_signed_distance (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic        rsp_is_inside,
   output logic signed [23:0] rsp_signed_distance,
   output logic [22:0] rsp_unsigned_distance,
   output logic [2:0]  rsp_face_index,
   output logic signed [23:0] rsp_closest_x,
   output logic signed [23:0] rsp_closest_y,
   output logic signed [23:0] rsp_closest_z,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);
   localparam int NS = pbsd_pkg::NSTAGE;
   logic [47:0] row0_ff, row1_ff, row2_ff;
   logic [59:0] trans_ff;
   logic [19:0] scale_ff, iscale_ff;
   logic [NS-1:0] vld_ff;
   logic en;
   logic signed [31:0] loc [3];
   // stage 5 regs
   logic signed [31:0] loc_ff [3];
   logic signed [32:0] gap_ff;
   logic [2:0] face_ff;
   logic ins_ff;
   logic [31:0] ex_ff [3];
   // stage 6
   logic [63:0] sum_ff;
   logic signed [32:0] gap6_ff;
   logic [2:0] face6_ff;
   logic ins6_ff;
   logic signed [31:0] loc6_ff [3];
   // delay line through the root
   logic signed [32:0] gapd_ff [33];
   logic [2:0] faced_ff [33];
   logic insd_ff [33];
   logic signed [31:0] locd_ff [33][3];
   logic [31:0] root;
   logic signed [53:0] prod_ff;
   logic [2:0] facep_ff;
   logic insp_ff;
   logic signed [31:0] locp_ff [3];
   pbsd_pkg::result_type res_in, res_ff;
   logic signed [32:0] g_in, gcur;
   logic [2:0] f_in;
   logic i_in;
   logic [31:0] e_in [3];
   logic signed [53:0] dist_q;

   function automatic logic [23:0] sat24(input logic signed [31:0] v);
      if (v > 32'sd8388607) return 24'h7fffff;
      if (v < -32'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

   assign en = !(rsp_valid && !rsp_ready);
   assign req_ready = en && !reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= 48'd16384;
         row1_ff <= 48'd16384 << 16;
         row2_ff <= 48'd16384 << 32;
         trans_ff <= '0;
         scale_ff <= 20'd1024;
         iscale_ff <= 20'd16384;
      end else if (csr_valid) begin
         case (csr_index)
            pbsd_pkg::CSR_ROW0: row0_ff <= csr_data[47:0];
            pbsd_pkg::CSR_ROW1: row1_ff <= csr_data[47:0];
            pbsd_pkg::CSR_ROW2: row2_ff <= csr_data[47:0];
            pbsd_pkg::CSR_TRANS: trans_ff <= csr_data;
            pbsd_pkg::CSR_SCALE: scale_ff <= csr_data[19:0];
            pbsd_pkg::CSR_ISCALE: iscale_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   pbsd_local u_local (
      .clock(clock), .en(en), .px(req_point_x), .py(req_point_y), .pz(req_point_z),
      .row0(row0_ff), .row1(row1_ff), .row2(row2_ff), .trans(trans_ff),
      .iscale(iscale_ff), .loc_out(loc)
   );

   // gap, face, inside flag and per-axis excess
   always_comb begin
      i_in = 1'b1;
      f_in = '0;
      g_in = 33'(pbsd_pkg::HALF_Q14) + 33'(loc[0]);
      for (int i = 0; i < 3; i++) begin
         if (loc[i] > 32'sd8192 || loc[i] < -32'sd8192) i_in = 1'b0;
         e_in[i] = (loc[i] > 32'sd8192) ? 32'(loc[i] - 32'sd8192) :
                   (loc[i] < -32'sd8192) ? 32'(-33'(loc[i]) - 33'sd8192) : 32'd0;
      end
      for (int k = 1; k < 6; k++) begin
         gcur = (k % 2 == 1) ? 33'(pbsd_pkg::HALF_Q14) - 33'(loc[k/2])
                             : 33'(pbsd_pkg::HALF_Q14) + 33'(loc[k/2]);
         if (gcur < g_in) begin
            g_in = gcur;
            f_in = 3'(k);
         end
      end
   end

   always_comb begin
      dist_q = (prod_ff + 54'sd512) >>> 10;
      res_in.is_inside = insp_ff;
      if (dist_q > 54'sd8388607) begin
         res_in.signed_distance = insp_ff ? 24'h800000 : 24'h7fffff;
         res_in.unsigned_distance = 23'h7fffff;
      end else begin
         res_in.signed_distance = insp_ff ? 24'(-dist_q) : 24'(dist_q);
         res_in.unsigned_distance = 23'(dist_q);
      end
      res_in.face_index = facep_ff;
      res_in.closest_x = sat24(locp_ff[0]);
      res_in.closest_y = sat24(locp_ff[1]);
      res_in.closest_z = sat24(locp_ff[2]);
      case (facep_ff)
         3'd0: res_in.closest_x = -24'sd8192;
         3'd1: res_in.closest_x = 24'sd8192;
         3'd2: res_in.closest_y = -24'sd8192;
         3'd3: res_in.closest_y = 24'sd8192;
         3'd4: res_in.closest_z = -24'sd8192;
         default: res_in.closest_z = 24'sd8192;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         loc_ff <= loc;
         gap_ff <= g_in;
         face_ff <= f_in;
         ins_ff <= i_in;
         ex_ff <= e_in;
         sum_ff <= 64'(ex_ff[0] * 64'(ex_ff[0])) + 64'(ex_ff[1] * 64'(ex_ff[1]))
                   + 64'(ex_ff[2] * 64'(ex_ff[2]));
         gap6_ff <= gap_ff;
         face6_ff <= face_ff;
         ins6_ff <= ins_ff;
         loc6_ff <= loc_ff;
         // 33 deep: matches the root's input register plus 32 bit stages
         gapd_ff[0] <= gap6_ff;
         faced_ff[0] <= face6_ff;
         insd_ff[0] <= ins6_ff;
         locd_ff[0] <= loc6_ff;
         for (int k = 1; k < 33; k++) begin
            gapd_ff[k] <= gapd_ff[k-1];
            faced_ff[k] <= faced_ff[k-1];
            insd_ff[k] <= insd_ff[k-1];
            locd_ff[k] <= locd_ff[k-1];
         end
         prod_ff <= insd_ff[32] ? 54'(gapd_ff[32]) * $signed({34'b0, scale_ff})
                                : $signed({22'b0, root}) * $signed({34'b0, scale_ff});
         facep_ff <= faced_ff[32];
         insp_ff <= insd_ff[32];
         locp_ff <= locd_ff[32];
         res_ff <= res_in;
      end
   end

   pbsd_sqrt u_sqrt (.clock(clock), .en(en), .n_in(sum_ff), .root(root));

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[NS-2:0], req_valid};
   end
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_is_inside = res_ff.is_inside;
   assign rsp_signed_distance = res_ff.signed_distance;
   assign rsp_unsigned_distance = res_ff.unsigned_distance;
   assign rsp_face_index = res_ff.face_index;
   assign rsp_closest_x = res_ff.closest_x;
   assign rsp_closest_y = res_ff.closest_y;
   assign rsp_closest_z = res_ff.closest_z;

   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `ASSERT_IMPL(a_face, clock, reset, rsp_valid |-> rsp_face_index <= 3'd5, "bad face")
   `ASSERT_IMPL(a_ins, clock, reset, (rsp_valid && rsp_is_inside) |-> (rsp_signed_distance[23] || rsp_signed_distance == 24'd0), "sign")
endmodule

[tb/pbsd_checker.sv]
`timescale 1ns / 1ps
// Watches the three channels of point_box_signed_distance, keeps a shadow of
// the register file, predicts each result word and compares it in order.
module pbsd_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_z,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic        rsp_is_inside,
   input  logic signed [23:0] rsp_signed_distance,
   input  logic [22:0] rsp_unsigned_distance,
   input  logic [2:0]  rsp_face_index,
   input  logic signed [23:0] rsp_closest_x,
   input  logic signed [23:0] rsp_closest_y,
   input  logic signed [23:0] rsp_closest_z,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data,
   output int   error_count,
   output int   pending_count,
   output int   result_count,
   output int   inside_count
);
   localparam longint HALF_Q14 = pbsd_pkg::HALF_Q14;
   localparam longint V_LIMIT = longint'(1) <<< 42;
   localparam longint L_MAX = 64'sd2147483647;
   localparam longint L_MIN = -64'sd2147483648;
   localparam longint OUT_MAX = 64'sd8388607;
   localparam longint OUT_MIN = -64'sd8388608;

   logic [47:0] rot_row [3];
   logic [59:0] box_center;
   logic [19:0] box_scale;
   logic [19:0] box_inv_scale;
   pbsd_pkg::result_type expected_words[$];

   function automatic longint clamp(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic pbsd_pkg::result_type box_distance(input logic signed [19:0] px,
         input logic signed [19:0] py, input logic signed [19:0] pz);
      longint d [3];
      longint loc [3];
      longint cl [3];
      longint v, g, best, dist_q, sd, ud, a, e;
      logic [63:0] sum, n;
      int face;
      bit in_box;
      pbsd_pkg::result_type r;
      d[0] = longint'(px) - longint'($signed(box_center[19:0]));
      d[1] = longint'(py) - longint'($signed(box_center[39:20]));
      d[2] = longint'(pz) - longint'($signed(box_center[59:40]));
      in_box = 1;
      for (int i = 0; i < 3; i++) begin
         v = 0;
         for (int j = 0; j < 3; j++)
            v += longint'($signed(rot_row[j][16*i +: 16])) * d[j];
         v = clamp(v, -V_LIMIT, V_LIMIT);
         v = (v * longint'(box_inv_scale) + (longint'(1) <<< 23)) >>> 24;
         loc[i] = clamp(v, L_MIN, L_MAX);
         if (loc[i] > HALF_Q14 || loc[i] < -HALF_Q14) in_box = 0;
      end
      // first smallest gap wins, in -x,+x,-y,+y,-z,+z order
      face = 0;
      best = HALF_Q14 + loc[0];
      for (int i = 1; i < 6; i++) begin
         g = (i % 2) ? (HALF_Q14 - loc[i/2]) : (HALF_Q14 + loc[i/2]);
         if (g < best) begin
            best = g;
            face = i;
         end
      end
      if (in_box) begin
         dist_q = (best * longint'(box_scale) + 512) >>> 10;
         sd = clamp(-dist_q, OUT_MIN, OUT_MAX);
      end else begin
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            a = (loc[i] < 0) ? -loc[i] : loc[i];
            e = (a > HALF_Q14) ? a - HALF_Q14 : 0;
            sum += 64'(e) * 64'(e);
         end
         n = int_sqrt(sum);
         dist_q = (longint'(n) * longint'(box_scale) + 512) >>> 10;
         sd = clamp(dist_q, OUT_MIN, OUT_MAX);
      end
      ud = (sd < 0) ? -sd : sd;
      if (ud > OUT_MAX) ud = OUT_MAX;
      for (int i = 0; i < 3; i++) cl[i] = clamp(loc[i], OUT_MIN, OUT_MAX);
      cl[face/2] = (face % 2) ? HALF_Q14 : -HALF_Q14;
      r.is_inside = in_box;
      r.signed_distance = sd[23:0];
      r.unsigned_distance = ud[22:0];
      r.face_index = face[2:0];
      r.closest_x = cl[0][23:0];
      r.closest_y = cl[1][23:0];
      r.closest_z = cl[2][23:0];
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pbsd_pkg::result_type w;
      if (reset) begin
         rot_row[0] = 48'd16384;
         rot_row[1] = 48'd16384 << 16;
         rot_row[2] = 48'd16384 << 32;
         box_center = '0;
         box_scale = 20'd1024;
         box_inv_scale = 20'd16384;
         expected_words.delete();
         error_count = 0;
         result_count = 0;
         inside_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pbsd_pkg::CSR_ROW0:   rot_row[0] = csr_data[47:0];
               pbsd_pkg::CSR_ROW1:   rot_row[1] = csr_data[47:0];
               pbsd_pkg::CSR_ROW2:   rot_row[2] = csr_data[47:0];
               pbsd_pkg::CSR_TRANS:  box_center = csr_data;
               pbsd_pkg::CSR_SCALE:  box_scale = csr_data[19:0];
               pbsd_pkg::CSR_ISCALE: box_inv_scale = csr_data[19:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing outstanding");
               error_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("is_inside", w.is_inside, rsp_is_inside);
               check_field("signed_distance", $signed(w.signed_distance),
                  rsp_signed_distance);
               check_field("unsigned_distance", w.unsigned_distance,
                  rsp_unsigned_distance);
               check_field("face_index", w.face_index, rsp_face_index);
               check_field("closest_x", $signed(w.closest_x), rsp_closest_x);
               check_field("closest_y", $signed(w.closest_y), rsp_closest_y);
               check_field("closest_z", $signed(w.closest_z), rsp_closest_z);
               result_count++;
               if (rsp_is_inside) inside_count++;
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(box_distance(req_point_x, req_point_y, req_point_z));
      end
      pending_count = expected_words.size();
   end
endmodule

[tb/point_box_signed_distance_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for point_box_signed_distance. Checking lives in
// pbsd_checker; this module drives points, register writes and stalls.
module point_box_signed_distance_tb;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 60;    // comfortably past the pipeline latency

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_x = 0;
   logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_y = 0;
   logic signed [pbsd_pkg::COORD_WIDTH-1:0] req_point_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic        rsp_is_inside;
   logic signed [23:0] rsp_signed_distance;
   logic [22:0] rsp_unsigned_distance;
   logic [2:0]  rsp_face_index;
   logic signed [23:0] rsp_closest_x;
   logic signed [23:0] rsp_closest_y;
   logic signed [23:0] rsp_closest_z;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0]  csr_index = 0;
   logic [59:0] csr_data = 0;

   int error_count, pending_count, result_count, inside_count;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;       // 0 never stall, 1 light random, 2 long stalls
   int stall_left = 0;
   int word_count = 0;

   // stimulus-side copy of the box, only used to aim points near it
   logic [59:0] aim_center = '0;
   logic [19:0] aim_scale = 20'd1024;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   point_box_signed_distance u_dut (.*);

   pbsd_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("point_box_signed_distance_tb NOT OK");
         $finish;
      end
   end

   // receiver: stall runs of random length, pattern depends on phase
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 0;
      end else begin
         rsp_ready = 1;
         if (stall_mode == 1 && $urandom_range(3) == 0)
            stall_left = $urandom_range(2);
         else if (stall_mode == 2 && $urandom_range(5) == 0)
            stall_left = $urandom_range(12, 3);
      end
   end

   // entered and left at a falling edge
   task automatic send_point(input logic [19:0] x, input logic [19:0] y,
         input logic [19:0] z);
      if (burst_left == 0) begin
         req_valid = 0;
         repeat ($urandom_range(6)) @(negedge clock);
         burst_left = $urandom_range(24, 1);
      end
      req_valid = 1;
      req_point_x = x;
      req_point_y = y;
      req_point_z = z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      word_count++;
   endtask

   task automatic wait_idle();
      req_valid = 0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [59:0] value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
      if (idx == pbsd_pkg::CSR_TRANS) aim_center = value;
      if (idx == pbsd_pkg::CSR_SCALE) aim_scale = value[19:0];
   endtask

   function automatic logic [15:0] rot_entry(input int kind);
      case (kind)
         0: return 16'd16384;
         1: return -16'sd16384;
         2: return 16'd11585;       // cos 45 deg
         3: return -16'sd11585;
         4: return 16'h7fff;
         5: return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   // point near the box center, a bit wider than the box in world units
   function automatic logic [19:0] near_coord(input int k);
      longint c, span;
      c = longint'($signed(aim_center[20*k +: 20]));
      span = longint'(aim_scale) / 2 + 64;
      if (span > 524287) span = 524287;
      c = c + $signed($urandom_range(32'(2 * span))) - span;
      if (c > 524287) c = 524287;
      if (c < -524288) c = -524288;
      return c[19:0];
   endfunction

   task automatic random_config(input int phase);
      logic [47:0] row;
      logic [19:0] s, inv;
      logic [59:0] t;
      int perm;
      for (int r = 0; r < 3; r++) begin
         if (phase % 3 == 0) begin
            row = 48'($urandom());
            row[47:32] = 16'($urandom());
         end else begin
            // signed permutation, or 45 deg mixes on odd phases
            perm = (r + phase) % 3;
            row = '0;
            row[16*perm +: 16] = rot_entry((phase % 2) ? $urandom_range(3)
               : $urandom_range(1));
            if (phase % 2) row[16*((perm + 1) % 3) +: 16] = rot_entry($urandom_range(3, 2));
         end
         write_reg(r[2:0] == 0 ? pbsd_pkg::CSR_ROW0 :
            (r == 1 ? pbsd_pkg::CSR_ROW1 : pbsd_pkg::CSR_ROW2), 60'(row));
      end
      case (phase % 6)
         0: s = 20'd0;
         1: s = 20'hfffff;
         2: s = 20'd1;
         3: s = 20'd1024 << $urandom_range(2);
         default: s = 20'($urandom_range(4096, 256));
      endcase
      if (s == 0 || $urandom_range(4) == 0) inv = 20'($urandom());
      else if ((64'd1 << 24) / s > 64'hfffff) inv = 20'hfffff;
      else inv = 20'((64'd1 << 24) / s);
      if (phase % 4 == 1) begin
         t = 60'({$urandom(), $urandom()});
      end else begin
         t[19:0] = 20'($signed($urandom_range(65536)) - 32768);
         t[39:20] = 20'($signed($urandom_range(65536)) - 32768);
         t[59:40] = 20'($signed($urandom_range(65536)) - 32768);
      end
      write_reg(pbsd_pkg::CSR_SCALE, 60'(s));
      write_reg(pbsd_pkg::CSR_ISCALE, 60'(inv));
      write_reg(pbsd_pkg::CSR_TRANS, t);
      if (phase % 5 == 2) write_reg(3'(6 + phase % 2), 60'({$urandom(), $urandom()}));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: identity box of edge 1.0 (half width 512 in Q10.10)
      send_point(20'd0, 20'd0, 20'd0);                       // tie, all faces equal
      send_point(20'sd512, 20'd0, 20'd0);                    // on +x face
      send_point(-20'sd512, 20'd0, 20'd0);
      send_point(20'd0, 20'sd512, 20'd0);
      send_point(20'd0, -20'sd512, 20'd0);
      send_point(20'd0, 20'd0, 20'sd512);
      send_point(20'd0, 20'd0, -20'sd512);
      send_point(20'sd513, 20'd0, 20'd0);                    // just outside
      send_point(20'sd512, 20'sd512, 20'sd512);              // corner
      send_point(20'sd600, -20'sd700, 20'sd800);
      send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);           // field extremes
      send_point(20'h80000, 20'h80000, 20'h80000);
      send_point(20'h7ffff, 20'h80000, 20'd0);
      send_point(20'sd100, -20'sd300, 20'sd256);
      wait_idle();

      // directed: zero scale, full-scale rotation, extreme translation
      write_reg(pbsd_pkg::CSR_SCALE, 60'd0);
      write_reg(pbsd_pkg::CSR_ROW0, 60'({16'h8000, 16'h7fff, 16'h8000}));
      write_reg(pbsd_pkg::CSR_TRANS, {20'h80000, 20'h7ffff, 20'h80000});
      write_reg(pbsd_pkg::CSR_ISCALE, 60'hfffff);
      send_point(20'h7ffff, 20'h80000, 20'h7ffff);
      send_point(20'd0, 20'd0, 20'd0);
      send_point(20'h80000, 20'h7ffff, 20'h80000);
      wait_idle();
      write_reg(3'd7, '1);                                   // ignored index
      send_point(20'sd5, 20'sd5, 20'sd5);
      wait_idle();

      for (int phase = 0; phase < 12; phase++) begin
         stall_mode = phase % 3;
         random_config(phase);
         for (int n = 0; n < 96; n++) begin
            if ($urandom_range(9) < 7)
               send_point(near_coord(0), near_coord(1), near_coord(2));
            else
               send_point(20'($urandom()), 20'($urandom()), 20'($urandom()));
         end
         wait_idle();
      end

      stall_mode = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d points (%0d inside, %0d outside) over 14 register settings",
         word_count, inside_count, result_count - inside_count);
      if (error_count == 0 && pending_count == 0 && result_count == word_count) begin
         $display("point_box_signed_distance_tb OK");
      end else begin
         $display("point_box_signed_distance_tb NOT OK");
      end
      $finish;
   end
endmodule
